// ----- hw/rtl/tie_averaged_ranker_top_assert.svh -----
// Assertion macros for the tie-averaged ranker.
// Used by the top level; relies on clk and arst_n in the including scope.
`ifndef TIE_AVERAGED_RANKER_TOP_ASSERT_SVH
`define TIE_AVERAGED_RANKER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// A condition that must hold at every clock edge outside reset.
`define TAR_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("tie ranker check failed: always");

// A condition that must hold in the cycle after the trigger.
`define TAR_ASSERT_NEXT(lbl, trig, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error("tie ranker check failed: next cycle");

`else

`define TAR_ASSERT_ALWAYS(lbl, cond)
`define TAR_ASSERT_NEXT(lbl, trig, cond)

`endif

`endif

// ----- hw/rtl/tar_pkg.sv -----
// Shared types, constants and helper functions of the tie-averaged ranker.
// No dependencies; used by tar_tie_store and tie_averaged_ranker_top.
package tar_pkg;

	// Field widths.
	localparam int IDX_W    = 16;
	localparam int VAL_W    = 32;
	localparam int HALVES_W = 18;
	localparam int DATA_W   = 32;
	localparam int PADDR_W  = 3;

	// Tie buffer geometry.
	localparam int TIE_DEPTH = 63;
	localparam int TADDR_W   = $clog2(TIE_DEPTH);
	localparam int COUNT_W   = 7;
	localparam int RANK_W    = 17;

	// Value patterns.
	localparam logic [VAL_W-1:0] MISSING_PATTERN = 32'hFF7F_FFFF;
	localparam logic [VAL_W-1:0] NEG_ZERO        = 32'h8000_0000;

	// Saturation limits of the counters and of the rank output.
	localparam logic [RANK_W:0]   COUNT_CAP  = 18'd65537;
	localparam logic [HALVES_W:0] HALVES_CAP = 19'd262143;

	// Register map, indexed by word.
	typedef enum logic [0:0] {
		REG_USE_SECOND = 1'b0
	} tar_reg_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MISS,
		ST_FLUSH
	} tar_state_t;

	// Write port of the tie store.
	typedef struct packed {
		logic               en;
		logic [TADDR_W-1:0] addr;
		logic [IDX_W-1:0]   data;
	} tar_wr_t;

	// Clamp a grown count to the counter limit.
	function automatic logic [RANK_W-1:0] count_sat(input logic [RANK_W:0] s);
		logic [RANK_W:0] r;
		begin
			r = (s > COUNT_CAP) ? COUNT_CAP : s;
			return r[RANK_W-1:0];
		end
	endfunction

endpackage

// ----- hw/rtl/tar_tie_store.sv -----
// Tie buffer memory: one write port and one registered read port.
// A read of the address being written returns the new data. Uses tar_pkg.
module tar_tie_store
	import tar_pkg::*;
(
	input  logic                clk,
	input  tar_wr_t             wr,
	input  logic [TADDR_W-1:0]  rd_addr,
	output logic [IDX_W-1:0]    rd_data
);

	logic [IDX_W-1:0] mem [TIE_DEPTH];
	logic [IDX_W-1:0] rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// Registered read with write-through forwarding on an address match.
	always_ff @(posedge clk) begin
		if (wr.en && (wr.addr == rd_addr)) begin
			rd_data_q <= wr.data;
		end else begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- hw/rtl/tie_averaged_ranker_top.sv -----
// Tie-averaged ranker: takes elements in ascending value order and returns each one, but
// ties past a full buffer, with its fractional rank in half-units, tied elements sharing the
// mean rank of their run. An element that opens or extends a run without is_last gives no
// result; a missing element gives its own result. The first read of the tie memory overlaps
// the cycle in which the closing item is taken (or its missing result leaves), and closing
// a run gives one result per buffered element, at most 63, since the single read port gives
// one stored index per cycle while the output is free. A new run opened by the closing item
// with is_last is flushed after the old one. Results leave through an output register, so a
// stalled consumer holds the block only while a result is pending. The tie memory needs no
// clearing pass after reset. Uses tar_pkg, tar_tie_store and the assert header.
`include "tie_averaged_ranker_top_assert.svh"

module tie_averaged_ranker_top
	import tar_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// Configuration port.
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]    pwdata,
	output logic [DATA_W-1:0]    prdata,
	output logic                 pready,
	// Input channel.
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [IDX_W-1:0]     element_index,
	input  logic [VAL_W-1:0]     value,
	input  logic [VAL_W-1:0]     second_value,
	input  logic                 is_last,
	// Output channel.
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [IDX_W-1:0]     ranked_index,
	output logic [HALVES_W-1:0]  rank_halves,
	output logic                 is_missing,
	output logic                 overflow,
	output logic                 last_result
);

	// Configuration.
	logic use_second_q;
	logic cfg_we;

	// Sequencer.
	tar_state_t state_q, state_d;

	// Run state.
	logic [COUNT_W-1:0] tie_count_q;
	logic [RANK_W-1:0]  run_length_q;
	logic [RANK_W-1:0]  next_rank_q;
	logic [VAL_W-1:0]   prev_value_q;
	logic               seen_valid_q;
	logic               overflow_q;

	// Item held while its results are produced.
	logic [IDX_W-1:0] idx_q;
	logic [VAL_W-1:0] norm_q;
	logic             last_q;
	logic             pend_open_q;

	// Flush read pointer.
	logic [TADDR_W-1:0] ptr_q, ptr_d;

	// Output register.
	logic                out_valid_q;
	logic [IDX_W-1:0]    out_idx_q;
	logic [HALVES_W-1:0] out_halves_q;
	logic                out_miss_q;
	logic                out_ovf_q;
	logic                out_last_q;

	// Decode of the incoming item.
	logic             accept;
	logic             in_miss;
	logic [VAL_W-1:0] in_norm;
	logic             in_tie;
	logic             tie_room;

	// Control pulses.
	logic                can_push;
	logic                emit;
	logic [IDX_W-1:0]    emit_idx;
	logic [HALVES_W-1:0] emit_halves;
	logic                emit_miss;
	logic                emit_last;
	logic                do_latch;
	logic                do_tie;
	logic                do_open_in;
	logic                do_open_q;
	logic                flush_done;
	logic                do_clear;
	logic                at_end;

	// Rank of the open run and memory connections.
	logic [HALVES_W:0]   halves_sum;
	logic [HALVES_W-1:0] run_halves;
	tar_wr_t             wr;
	logic [IDX_W-1:0]    rd_data;

	// Configuration register and read-back.
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_second_q <= 1'b0;
		end else if (cfg_we && (paddr[2] == REG_USE_SECOND)) begin
			use_second_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			REG_USE_SECOND: prdata = {{(DATA_W-1){1'b0}}, use_second_q};
			default:        prdata = '0;
		endcase
	end

	// Classification of the incoming item.
	assign in_miss  = (value == MISSING_PATTERN) ||
	                  (use_second_q && (second_value == MISSING_PATTERN));
	assign in_norm  = (value == NEG_ZERO) ? '0 : value;
	assign in_tie   = !in_miss && seen_valid_q && (in_norm == prev_value_q);
	assign tie_room = tie_count_q < COUNT_W'(TIE_DEPTH);
	assign accept   = in_valid && in_ready;

	// Rank of the open run: twice the first rank plus run length less one.
	assign halves_sum = {1'b0, next_rank_q, 1'b0} + {2'b00, run_length_q} - 19'd1;
	assign run_halves = (halves_sum > HALVES_CAP) ? HALVES_CAP[HALVES_W-1:0]
	                                              : halves_sum[HALVES_W-1:0];

	assign can_push = !out_valid_q || out_ready;
	assign at_end   = (({1'b0, ptr_q}) + COUNT_W'(1)) == tie_count_q;

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and control.
	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		emit        = 1'b0;
		emit_idx    = rd_data;
		emit_halves = run_halves;
		emit_miss   = 1'b0;
		emit_last   = 1'b0;
		do_latch    = 1'b0;
		do_tie      = 1'b0;
		do_open_in  = 1'b0;
		do_open_q   = 1'b0;
		flush_done  = 1'b0;
		do_clear    = 1'b0;
		wr          = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (accept) begin
					do_latch = 1'b1;
					if (in_miss) begin
						state_d = ST_MISS;
					end else if (in_tie) begin
						do_tie  = 1'b1;
						wr.en   = tie_room;
						wr.addr = tie_count_q[TADDR_W-1:0];
						wr.data = element_index;
						if (is_last) begin
							state_d = ST_FLUSH;
						end
					end else if (seen_valid_q) begin
						state_d = ST_FLUSH;
					end else begin
						do_open_in = 1'b1;
						wr.en      = 1'b1;
						wr.addr    = '0;
						wr.data    = element_index;
						if (is_last) begin
							state_d = ST_FLUSH;
						end
					end
				end
			end
			ST_MISS: begin
				if (can_push) begin
					emit        = 1'b1;
					emit_idx    = idx_q;
					emit_halves = '0;
					emit_miss   = 1'b1;
					emit_last   = !(last_q && seen_valid_q);
					if (last_q && seen_valid_q) begin
						state_d = ST_FLUSH;
					end else begin
						do_clear = last_q;
						state_d  = ST_IDLE;
					end
				end
			end
			ST_FLUSH: begin
				if (can_push) begin
					emit = 1'b1;
					// Only a new run still to be flushed for is_last comes after this one.
					emit_last = at_end && !(pend_open_q && last_q);
					if (at_end) begin
						flush_done = 1'b1;
						if (pend_open_q) begin
							do_open_q = 1'b1;
							wr.en     = 1'b1;
							wr.addr   = '0;
							wr.data   = idx_q;
							state_d   = last_q ? ST_FLUSH : ST_IDLE;
						end else begin
							do_clear = last_q;
							state_d  = ST_IDLE;
						end
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Read pointer: steps through the run, restarts at zero on entry to a flush.
	always_comb begin
		if ((state_q == ST_FLUSH) && (state_d == ST_FLUSH) && !flush_done) begin
			ptr_d = emit ? ptr_q + TADDR_W'(1) : ptr_q;
		end else begin
			ptr_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else begin
			ptr_q <= ptr_d;
		end
	end

	// Tie buffer memory, read one entry ahead of the output.
	tar_tie_store u_store (
		.clk     (clk),
		.wr      (wr),
		.rd_addr (ptr_d),
		.rd_data (rd_data)
	);

	// Item fields held across the results of one item.
	always_ff @(posedge clk) begin
		if (do_latch) begin
			idx_q  <= element_index;
			norm_q <= in_norm;
			last_q <= is_last;
		end
	end

	// Pending open of a new run after the old one is flushed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_open_q <= 1'b0;
		end else if (do_latch) begin
			pend_open_q <= !in_miss && !in_tie && seen_valid_q;
		end else if (flush_done) begin
			pend_open_q <= 1'b0;
		end
	end

	// Run state: extend, open, close and clear.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tie_count_q  <= '0;
			run_length_q <= '0;
			next_rank_q  <= RANK_W'(1);
			prev_value_q <= '0;
			seen_valid_q <= 1'b0;
			overflow_q   <= 1'b0;
		end else if (do_clear) begin
			tie_count_q  <= '0;
			run_length_q <= '0;
			next_rank_q  <= RANK_W'(1);
			prev_value_q <= '0;
			seen_valid_q <= 1'b0;
			overflow_q   <= 1'b0;
		end else begin
			if (flush_done) begin
				next_rank_q <= count_sat({1'b0, next_rank_q} + {1'b0, run_length_q});
			end
			// A new run opened as the old one closes takes the place of the closed one.
			if (do_open_in || do_open_q) begin
				tie_count_q  <= COUNT_W'(1);
				run_length_q <= RANK_W'(1);
				prev_value_q <= do_open_in ? in_norm : norm_q;
				seen_valid_q <= 1'b1;
			end else if (flush_done) begin
				tie_count_q  <= '0;
				run_length_q <= '0;
				seen_valid_q <= 1'b0;
			end else if (do_tie) begin
				if (tie_room) begin
					tie_count_q <= tie_count_q + COUNT_W'(1);
				end else begin
					overflow_q <= 1'b1;
				end
				run_length_q <= count_sat({1'b0, run_length_q} + 18'd1);
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_idx_q    <= emit_idx;
			out_halves_q <= emit_halves;
			out_miss_q   <= emit_miss;
			out_ovf_q    <= overflow_q;
			out_last_q   <= emit_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign ranked_index = out_idx_q;
	assign rank_halves  = out_halves_q;
	assign is_missing   = out_miss_q;
	assign overflow     = out_ovf_q;
	assign last_result  = out_last_q;

	// Checks on the run bookkeeping.
	`TAR_ASSERT_ALWAYS(a_count_bound, tie_count_q <= COUNT_W'(TIE_DEPTH))
	`TAR_ASSERT_ALWAYS(a_seen_matches_len, seen_valid_q == (run_length_q != '0))
	`TAR_ASSERT_ALWAYS(a_flush_has_run, (state_q != ST_FLUSH) || (tie_count_q != '0))
	`TAR_ASSERT_ALWAYS(a_ptr_in_run, (state_q != ST_FLUSH) || (({1'b0, ptr_q}) < tie_count_q))
	`TAR_ASSERT_NEXT(a_clear_rank, do_clear, (next_rank_q == RANK_W'(1)) && !overflow_q)

endmodule

// ----- verif/tar_rank_checker.sv -----
`timescale 1ns / 100ps
// Result checker for the tie-averaged ranker. It follows register writes and both item
// channels, predicts the ranked results of every accepted item and compares them in order.
// Depends on tar_pkg for field widths, value patterns, limits and the register map.
module tar_rank_checker
	import tar_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic                pready,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [DATA_W-1:0]   pwdata,
	input  logic                in_valid,
	input  logic                in_ready,
	input  logic [IDX_W-1:0]    element_index,
	input  logic [VAL_W-1:0]    value,
	input  logic [VAL_W-1:0]    second_value,
	input  logic                is_last,
	input  logic                out_valid,
	input  logic                out_ready,
	input  logic [IDX_W-1:0]    ranked_index,
	input  logic [HALVES_W-1:0] rank_halves,
	input  logic                is_missing,
	input  logic                overflow,
	input  logic                last_result,
	output int                  rank_errors,
	output int                  ranks_due
);

	typedef struct packed {
		logic [IDX_W-1:0]    index;
		logic [HALVES_W-1:0] halves;
		logic                missing;
		logic                ovf;
		logic                closes;
	} rank_t;

	// Ranks still to come out of the block, oldest first, and those of the current item.
	rank_t expected_ranks[$];
	rank_t item_ranks[$];

	// Our own copy of the configuration and of the open tie run.
	logic             use_second;
	logic [IDX_W-1:0] tie_index [TIE_DEPTH];
	int unsigned      tie_fill;
	int unsigned      run_length;
	int unsigned      first_rank;
	logic [VAL_W-1:0] run_value;
	logic             run_open;
	logic             ovf_flag;
	int               mismatches;

	// A data set ends: ranks start again from one and the sticky flag drops.
	task automatic clear_run_state();
		tie_fill   = 0;
		run_length = 0;
		first_rank = 1;
		run_value  = '0;
		run_open   = 1'b0;
		ovf_flag   = 1'b0;
	endtask

	// Counts of elements stop at the counter limit rather than wrapping.
	function automatic int unsigned count_grow(input int unsigned a, input int unsigned b);
		int unsigned s;
		s = a + b;
		return (s > COUNT_CAP) ? int'(COUNT_CAP) : s;
	endfunction

	task automatic add_rank(input logic [IDX_W-1:0] idx, input int unsigned halves,
			input logic missing);
		rank_t r;
		r.index   = idx;
		r.halves  = HALVES_W'(halves);
		r.missing = missing;
		r.ovf     = ovf_flag;
		r.closes  = 1'b0;
		item_ranks.push_back(r);
	endtask

	// Every buffered element of the run gets twice the mean rank of the run; elements
	// dropped on overflow still count towards the run length.
	task automatic close_run();
		int unsigned halves;
		int unsigned i;
		if (run_open && run_length != 0) begin
			halves = 2 * first_rank + run_length - 1;
			if (halves > HALVES_CAP)
				halves = HALVES_CAP;
			for (i = 0; i < tie_fill; i++)
				add_rank(tie_index[i], halves, 1'b0);
			first_rank = count_grow(first_rank, run_length);
			tie_fill   = 0;
			run_length = 0;
			run_open   = 1'b0;
		end
	endtask

	task automatic predict_ranks(input logic [IDX_W-1:0] idx, input logic [VAL_W-1:0] val,
			input logic [VAL_W-1:0] sec, input logic last);
		logic             missing;
		logic [VAL_W-1:0] norm;
		rank_t            r;
		item_ranks.delete();
		missing = (val == MISSING_PATTERN) || (use_second && sec == MISSING_PATTERN);
		norm    = (val == NEG_ZERO) ? '0 : val;
		if (missing) begin
			// A missing element leaves at once and does not touch the run.
			add_rank(idx, 0, 1'b1);
		end else if (run_open && norm == run_value) begin
			if (tie_fill < TIE_DEPTH) begin
				tie_index[tie_fill] = idx;
				tie_fill++;
			end else begin
				ovf_flag = 1'b1;
			end
			run_length = count_grow(run_length, 1);
		end else begin
			close_run();
			tie_index[0] = idx;
			tie_fill     = 1;
			run_length   = 1;
			run_value    = norm;
			run_open     = 1'b1;
		end
		if (last)
			close_run();
		// The final rank of the item carries the closing mark.
		if (item_ranks.size() > 0) begin
			r = item_ranks.pop_back();
			r.closes = 1'b1;
			item_ranks.push_back(r);
		end
		if (last)
			clear_run_state();
		foreach (item_ranks[k])
			expected_ranks.push_back(item_ranks[k]);
	endtask

	task automatic note_mismatch(input string what, input rank_t want, input rank_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: rank %s: expected idx=%h halves=%0d miss=%b ovf=%b last=%b, got idx=%h halves=%0d miss=%b ovf=%b last=%b",
				$realtime, what, want.index, want.halves, want.missing, want.ovf, want.closes,
				got.index, got.halves, got.missing, got.ovf, got.closes);
	endtask

	// Results are compared before the item of the same edge is predicted.
	always @(posedge clk or negedge arst_n) begin
		rank_t want;
		rank_t got;
		if (!arst_n) begin
			use_second = 1'b0;
			clear_run_state();
			expected_ranks.delete();
			mismatches = 0;
			rank_errors <= 0;
			ranks_due <= 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr[PADDR_W-1:2] == REG_USE_SECOND)
				use_second = pwdata[0];
			if (out_valid && out_ready) begin
				got = {ranked_index, rank_halves, is_missing, overflow, last_result};
				if (expected_ranks.size() == 0) begin
					note_mismatch("with none pending", '0, got);
				end else begin
					want = expected_ranks.pop_front();
					if (want != got)
						note_mismatch("mismatch", want, got);
				end
			end
			if (in_valid && in_ready)
				predict_ranks(element_index, value, second_value, is_last);
			rank_errors <= mismatches;
			ranks_due <= expected_ranks.size();
		end
	end

endmodule

// ----- verif/tie_averaged_ranker_top_test.sv -----
`timescale 1ns / 100ps
// Testbench top for the tie-averaged ranker: writes the register, sends directed and random
// data sets with random pacing on both channels, and reports the verdict.
// Depends on tar_pkg, tie_averaged_ranker_top and tar_rank_checker.
module tie_averaged_ranker_top_test;
	import tar_pkg::*;

	localparam int SPARE_REG     = 1;    // no register lives here, so writes are ignored
	localparam int IDLE_LIMIT    = 2000;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 80;

	localparam logic [VAL_W-1:0] POS_ZERO     = 32'h0000_0000;
	localparam logic [VAL_W-1:0] ONE_F        = 32'h3F80_0000;
	localparam logic [VAL_W-1:0] TWO_F        = 32'h4000_0000;
	localparam logic [VAL_W-1:0] QUIET_NAN    = 32'h7FC0_0000;
	localparam logic [VAL_W-1:0] ALL_ONES     = 32'hFFFF_FFFF;
	localparam logic [VAL_W-1:0] NEAR_MISSING = 32'hFF7F_FFFE;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                in_valid;
	logic                in_ready;
	logic [IDX_W-1:0]    element_index;
	logic [VAL_W-1:0]    value;
	logic [VAL_W-1:0]    second_value;
	logic                is_last;
	logic                out_valid;
	logic                out_ready;
	logic [IDX_W-1:0]    ranked_index;
	logic [HALVES_W-1:0] rank_halves;
	logic                is_missing;
	logic                overflow;
	logic                last_result;
	int                  rank_errors;
	int                  ranks_due;

	logic gaps_on;
	logic hold_request;
	int   items_sent;

	tie_averaged_ranker_top i_dut (.*);

	tar_rank_checker i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// A register write: setup cycle, then access cycle until pready.
	task automatic write_reg(input int unsigned index, input logic [DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'(index * 4);
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Offer one element, with an occasional gap before it, and wait for acceptance.
	task automatic offer(input logic [IDX_W-1:0] idx, input logic [VAL_W-1:0] val,
			input logic [VAL_W-1:0] sec, input logic last);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid <= 1'b1;
		element_index <= idx;
		value <= val;
		second_value <= sec;
		is_last <= last;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	// Wait until every expected rank has come out, then let the block finish its clearing.
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (ranks_due != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return POS_ZERO;
			1: return NEG_ZERO;
			2: return QUIET_NAN;
			3: return ALL_ONES;
			default: return $urandom;
		endcase
	endfunction

	// One data set: runs of equal values with random content, stray missing elements,
	// and optionally a fresh value on the closing element.
	task automatic send_data_set(input int unsigned length, input int unsigned change_pct,
			input logic miss_on, input logic end_on_new);
		logic [VAL_W-1:0] run_val;
		logic [VAL_W-1:0] val;
		logic [VAL_W-1:0] sec;
		logic [IDX_W-1:0] idx;
		int unsigned      k;
		run_val = pick_value();
		idx = $urandom;
		for (k = 0; k < length; k++) begin
			if (k != 0 && $urandom_range(0, 99) < change_pct)
				run_val = pick_value();
			if (end_on_new && k != 0 && k == length - 1)
				run_val = run_val ^ 32'h1;
			val = run_val;
			// Zero runs mix both signs.
			if (val == POS_ZERO || val == NEG_ZERO)
				val = $urandom_range(0, 1) ? NEG_ZERO : POS_ZERO;
			sec = $urandom;
			if (miss_on) begin
				case ($urandom_range(0, 11))
					0: val = MISSING_PATTERN;
					1: sec = MISSING_PATTERN;
					default: ;
				endcase
			end
			offer(idx, val, sec, k == length - 1);
			idx = ($urandom_range(0, 7) == 0) ? IDX_W'($urandom) : idx + 1'b1;
		end
	endtask

	// Mostly tied runs; now and then a set in which every element draws a new value.
	task automatic send_short_set();
		send_data_set($urandom_range(1, 12), ($urandom_range(0, 7) == 0) ? 100 : 40, 1'b1,
			$urandom_range(0, 1));
	endtask

	// Receiver pacing, with one long hold-off on request.
	always begin
		@(posedge clk);
		if (hold_request) begin
			hold_request = 1'b0;
			out_ready <= 1'b0;
			repeat (HOLD_CYCLES) @(posedge clk);
		end else if (gaps_on && $urandom_range(0, 3) == 0) begin
			out_ready <= 1'b0;
			repeat ($urandom_range(0, 6)) @(posedge clk);
		end else begin
			out_ready <= 1'b1;
			repeat ($urandom_range(0, 11)) @(posedge clk);
		end
	end

	// Watchdog: the run ends if no item moves on either channel for too long.
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Verification failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		element_index = '0;
		value = '0;
		second_value = '0;
		is_last = 1'b0;
		out_ready = 1'b0;
		gaps_on = 1'b1;
		hold_request = 1'b0;
		items_sent = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A write to an unmapped address must leave the second value ignored.
		write_reg(SPARE_REG, ALL_ONES);

		// Directed set with second values ignored: signed zeros tie, NaN patterns tie by
		// bit pattern, missing elements inside a run, and every way of closing a data set.
		offer(16'h0000, POS_ZERO, MISSING_PATTERN, 1'b0);
		offer(16'hFFFF, NEG_ZERO, ALL_ONES, 1'b0);
		offer(16'h0005, MISSING_PATTERN, POS_ZERO, 1'b0);
		offer(16'h0006, ONE_F, POS_ZERO, 1'b0);
		offer(16'h0007, QUIET_NAN, ONE_F, 1'b0);
		offer(16'h0008, QUIET_NAN, ONE_F, 1'b0);
		offer(16'h0009, ALL_ONES, POS_ZERO, 1'b1);
		offer(16'h000A, MISSING_PATTERN, POS_ZERO, 1'b1);
		offer(16'h000B, 32'h1234_5678, POS_ZERO, 1'b0);
		offer(16'h000C, MISSING_PATTERN, ALL_ONES, 1'b1);
		offer(16'h000D, ALL_ONES, ALL_ONES, 1'b1);
		offer(16'h000E, NEG_ZERO, POS_ZERO, 1'b0);
		offer(16'h000F, NEG_ZERO, POS_ZERO, 1'b0);
		offer(16'h0010, POS_ZERO, POS_ZERO, 1'b1);
		settle();

		// Only bit 0 of the register counts.
		write_reg(REG_USE_SECOND, ALL_ONES);
		offer(16'h0014, TWO_F, MISSING_PATTERN, 1'b0);
		offer(16'h0015, TWO_F, POS_ZERO, 1'b0);
		offer(16'h0016, TWO_F, MISSING_PATTERN, 1'b0);
		offer(16'h0017, TWO_F, NEAR_MISSING, 1'b1);
		offer(16'hFFFF, MISSING_PATTERN, MISSING_PATTERN, 1'b1);
		offer(16'h0000, ALL_ONES, ALL_ONES, 1'b1);
		settle();

		// Random sets with missing second values active; one long tie run overflows the
		// buffer while the receiver holds off, so the block backs up.
		while (items_sent < 70)
			send_short_set();
		hold_request = 1'b1;
		send_data_set(90, 0, 1'b1, 1'b1);
		while (items_sent < 190)
			send_short_set();
		settle();

		write_reg(REG_USE_SECOND, 32'hFFFF_FFFE);
		while (items_sent < 250)
			send_short_set();
		settle();

		// Last part without any idling: a run that fills the buffer exactly, then more sets.
		write_reg(REG_USE_SECOND, 32'h0000_0001);
		gaps_on = 1'b0;
		send_data_set(64, 0, 1'b0, 1'b1);
		while (items_sent < 330)
			send_short_set();
		settle();

		if (rank_errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/tar_pkg.sv
hw/rtl/tar_tie_store.sv
hw/rtl/tie_averaged_ranker_top.sv
verif/tar_rank_checker.sv
verif/tie_averaged_ranker_top_test.sv
